// ===== hw/rtl/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg
// shared widths and codes of the rate monotonic tick scheduler
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int KIND_W     = 1;
  localparam int ID_W       = 4;
  localparam int FIELD_W    = 16;
  localparam int SLOT_W     = 16;
  localparam int TC_W       = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYPERPERIOD = 4'd1;

endpackage

// ===== hw/rtl/rmts_if.sv =====
// ----------------------------------------------------------------------------
// rmts_if
// request, result and configuration channels of the tick scheduler
// ----------------------------------------------------------------------------
interface rmts_in_if;
  import rmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ID_W-1:0]      task_index;
  logic [FIELD_W-1:0]   exec_time;
  logic [FIELD_W-1:0]   period;
  modport source (output valid, kind, task_index, exec_time, period, input ready);
  modport sink   (input valid, kind, task_index, exec_time, period, output ready);
endinterface

interface rmts_out_if;
  import rmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SLOT_W-1:0]    slot_number;
  logic [ID_W-1:0]      task_id;
  logic                 idle;
  logic                 overrun;
  logic                 frame_end;
  modport source (output valid, slot_number, task_id, idle, overrun, frame_end,
                  input ready);
  modport sink   (input valid, slot_number, task_id, idle, overrun, frame_end,
                  output ready);
endinterface

interface rmts_cfg_if;
  import rmts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rate_monotonic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// periodic task table in one memory; each tick without overrun runs the ready
// task with the shortest period and advances every active period timer
// ----------------------------------------------------------------------------
// load request: accepted only while no tick is in work, no result
// tick request, n active tasks: two passes over the task memory (one entry a cycle),
//   a first that picks the task and checks for overrun, a second that advances the
//   timers; an overrun stops after the first pass, and no active task skips both
// a finished result waits in the output register while the next request runs
// reset: slot counter and overrun flag cleared, task_count 0, hyperperiod 1, memory kept
module rate_monotonic_tick_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rmts_in_if.sink     in_ch,
  rmts_out_if.source  out_ch,
  rmts_cfg_if.sink    cfg_ch
);
  import rmts_pkg::*;

  localparam int TW    = TIME_WIDTH;
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef struct packed {
    logic [TW-1:0] exec_budget;
    logic [TW-1:0] task_period;
    logic [TW-1:0] remaining_budget;
    logic [TW-1:0] time_to_period_end;
  } entry_t;

  entry_t mem [MAX_TASKS];
  entry_t rd_data_r;

  logic [1:0]        state_r, state_nxt;
  logic [TC_W-1:0]   task_count_r;
  logic [SLOT_W-1:0] hyperperiod_r;
  logic [SLOT_W-1:0] slot_counter_r, slot_counter_nxt;
  logic              overrun_seen_r, overrun_seen_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r;
  logic [CNT_W-1:0]  rd_tag_r;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  chosen_r, chosen_nxt;
  logic [TW-1:0]     best_r, best_nxt;
  logic              ovr_new_r, ovr_new_nxt;
  logic              res_ovr_r, res_ovr_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic              cur_last_r, cur_last_nxt;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_idle_r;
  logic              out_ovr_r;
  logic              out_fe_r;

  logic [CNT_W-1:0]  active_n;
  logic [SLOT_W-1:0] hp_eff;
  logic              in_acc;
  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              last_ent;
  logic              ent_ovr;
  logic [TW-1:0]     ld_exec;
  logic [TW-1:0]     ld_per;
  logic [TW-1:0]     rem_chg;
  logic [TW-1:0]     ttpe_dec;
  logic              res_load;
  logic [SLOT_W-1:0] slot_adv;

  assign active_n = (32'(task_count_r) > 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                         : CNT_W'(task_count_r);
  assign hp_eff   = (hyperperiod_r == '0) ? SLOT_W'(1) : hyperperiod_r;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign ld_exec  = TW'(in_ch.exec_time);
  assign ld_per   = (TW'(in_ch.period) == '0) ? TW'(1) : TW'(in_ch.period);
  assign last_ent = rd_vld_r && ((rd_tag_r + CNT_W'(1)) == active_n);
  assign ent_ovr  = rd_data_r.remaining_budget > rd_data_r.time_to_period_end;
  assign rem_chg  = (found_r && (rd_tag_r[IDX_W-1:0] == chosen_r))
                    ? rd_data_r.remaining_budget - TW'(1)
                    : rd_data_r.remaining_budget;
  assign ttpe_dec = rd_data_r.time_to_period_end - TW'(1);
  assign slot_adv = cur_last_r ? '0 : cur_slot_r + SLOT_W'(1);
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = rd_tag_r[IDX_W-1:0];
    mem_wdata = rd_data_r;
    if (state_r == ST_IDLE) begin
      mem_waddr = IDX_W'(in_ch.task_index);
      mem_wdata = '{exec_budget: ld_exec, task_period: ld_per,
                    remaining_budget: ld_exec, time_to_period_end: ld_per};
      mem_we    = in_acc && (in_ch.kind == KIND_LOAD) &&
                  (32'(in_ch.task_index) < 32'(MAX_TASKS));
    end else if (state_r == ST_UPD) begin
      mem_we = rd_vld_r;
      if (ttpe_dec == '0) begin
        mem_wdata.remaining_budget   = rd_data_r.exec_budget;
        mem_wdata.time_to_period_end = rd_data_r.task_period;
      end else begin
        mem_wdata.remaining_budget   = rem_chg;
        mem_wdata.time_to_period_end = ttpe_dec;
      end
    end
    if ((state_r == ST_SCAN || state_r == ST_UPD) && (rd_idx_r < active_n)) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    slot_counter_nxt = slot_counter_r;
    overrun_seen_nxt = overrun_seen_r;
    rd_idx_nxt       = mem_re ? rd_idx_r + CNT_W'(1) : rd_idx_r;
    found_nxt        = found_r;
    chosen_nxt       = chosen_r;
    best_nxt         = best_r;
    ovr_new_nxt      = ovr_new_r;
    res_ovr_nxt      = res_ovr_r;
    cur_slot_nxt     = cur_slot_r;
    cur_last_nxt     = cur_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.kind == KIND_TICK)) begin
          cur_slot_nxt = slot_counter_r;
          cur_last_nxt = ({1'b0, slot_counter_r} + 17'd1) >= {1'b0, hp_eff};
          found_nxt    = 1'b0;
          ovr_new_nxt  = 1'b0;
          rd_idx_nxt   = '0;
          if (active_n == '0) begin
            res_ovr_nxt = overrun_seen_r;
            if (!overrun_seen_r) begin
              slot_counter_nxt = cur_last_nxt ? '0 : slot_counter_r + SLOT_W'(1);
            end
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_r) begin
          if (ent_ovr) begin
            ovr_new_nxt = 1'b1;
          end
          if ((rd_data_r.remaining_budget != '0) &&
              (!found_r || (rd_data_r.task_period < best_r))) begin
            found_nxt  = 1'b1;
            chosen_nxt = rd_tag_r[IDX_W-1:0];
            best_nxt   = rd_data_r.task_period;
          end
        end
        if (last_ent) begin
          if (overrun_seen_r || ovr_new_r || ent_ovr) begin
            overrun_seen_nxt = 1'b1;
            res_ovr_nxt      = 1'b1;
            state_nxt        = ST_DONE;
          end else begin
            res_ovr_nxt = 1'b0;
            rd_idx_nxt  = '0;
            state_nxt   = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (last_ent) begin
          slot_counter_nxt = slot_adv;
          state_nxt        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      task_count_r   <= '0;
      hyperperiod_r  <= SLOT_W'(1);
      slot_counter_r <= '0;
      overrun_seen_r <= 1'b0;
      rd_idx_r       <= '0;
      rd_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      slot_counter_r <= slot_counter_nxt;
      overrun_seen_r <= overrun_seen_nxt;
      rd_idx_r       <= rd_idx_nxt;
      rd_vld_r       <= mem_re;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TASK_COUNT:  task_count_r  <= cfg_ch.data[TC_W-1:0];
          REG_HYPERPERIOD: hyperperiod_r <= cfg_ch.data[SLOT_W-1:0];
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r   <= rd_idx_r;
    found_r    <= found_nxt;
    chosen_r   <= chosen_nxt;
    best_r     <= best_nxt;
    ovr_new_r  <= ovr_new_nxt;
    res_ovr_r  <= res_ovr_nxt;
    cur_slot_r <= cur_slot_nxt;
    cur_last_r <= cur_last_nxt;
    if (res_load) begin
      out_slot_r <= cur_slot_r;
      out_fe_r   <= cur_last_r;
      out_ovr_r  <= res_ovr_r;
      out_idle_r <= res_ovr_r || !found_r;
      out_id_r   <= (res_ovr_r || !found_r) ? '0 : ID_W'(chosen_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.slot_number = out_slot_r;
  assign out_ch.task_id     = out_id_r;
  assign out_ch.idle        = out_idle_r;
  assign out_ch.overrun     = out_ovr_r;
  assign out_ch.frame_end   = out_fe_r;

endmodule

// ===== hw/rtl/rmts_checker.sv =====
// ----------------------------------------------------------------------------
// rmts_checker
// port level checks of the tick scheduler, bound to the top level
// ----------------------------------------------------------------------------
module rmts_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [rmts_pkg::KIND_W-1:0] in_kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rmts_pkg::SLOT_W-1:0] out_slot_number,
  input logic                      out_overrun
);
  import rmts_pkg::*;

  logic [1:0] pending_r;
  logic       seen_ovr_r;
  logic       tick_acc;
  logic       res_acc;

  assign tick_acc = in_valid && in_ready && (in_kind == KIND_TICK);
  assign res_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      seen_ovr_r <= 1'b0;
    end else begin
      pending_r <= pending_r + 2'(tick_acc) - 2'(res_acc);
      if (res_acc && out_overrun) begin
        seen_ovr_r <= 1'b1;
      end
    end
  end

  // a result only for a tick request not yet answered
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result without an outstanding tick request");

  // overrun is sticky across results
  a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && seen_ovr_r) |-> out_overrun)
    else $error("overrun flag dropped after being reported");

  // at most one tick in work and one result waiting
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("too many outstanding tick requests");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_slot_number)))
    else $error("stalled result changed");

endmodule

bind rate_monotonic_tick_scheduler rmts_checker u_rmts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_slot_number (out_ch.slot_number),
  .out_overrun     (out_ch.overrun)
);

// ===== verif/tb_rate_monotonic_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rate_monotonic_tick_scheduler
// Drives load and tick requests into the scheduler, predicts every slot
// result from a task table kept in the bench, and checks each result in
// order. Directed cases come first: default reset, zero period, priority
// order with ties, and slot counter wrap. Random task sets follow, kept
// below the rate monotonic bound so they never overrun. The sticky overrun
// case runs last, because only reset clears it.
// ----------------------------------------------------------------------------
module tb_rate_monotonic_tick_scheduler;
  import rmts_pkg::*;

  localparam int NUM_TASKS   = 16;
  localparam int DRAIN_PAUSE = 2 * NUM_TASKS + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQS = 400;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              idle;
    logic              overrun;
    logic              frame_end;
  } slot_res_t;

  logic clk;
  logic rst_n;

  rmts_in_if  in_ch ();
  rmts_out_if out_ch ();
  rmts_cfg_if cfg_ch ();

  rate_monotonic_tick_scheduler #(
    .MAX_TASKS  (NUM_TASKS),
    .TIME_WIDTH (FIELD_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // scheduler state as the bench sees it
  logic [FIELD_W-1:0] tbl_exec   [NUM_TASKS];
  logic [FIELD_W-1:0] tbl_period [NUM_TASKS];
  logic [FIELD_W-1:0] tbl_left   [NUM_TASKS];
  logic [FIELD_W-1:0] tbl_ttpe   [NUM_TASKS];
  logic [SLOT_W-1:0]  slot_ctr;
  logic               ovr_flag;
  logic [TC_W-1:0]    cfg_tasks;
  logic [FIELD_W-1:0] cfg_hyper;

  slot_res_t expected_slots[$];

  int mismatch_count;
  int results_checked;
  int load_count;
  int tick_count;
  int run_count;
  int idle_count;
  int overrun_count;
  int send_gap_pct;
  int recv_gap_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic advance_schedule(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] idx,
                                  input logic [FIELD_W-1:0] exec_t,
                                  input logic [FIELD_W-1:0] per);
    int n;
    int hp;
    bit last;
    bit found;
    int chosen;
    logic [FIELD_W-1:0] best;
    slot_res_t r;
    n = (cfg_tasks > NUM_TASKS) ? NUM_TASKS : cfg_tasks;
    hp = (cfg_hyper == 0) ? 1 : cfg_hyper;
    last = (int'(slot_ctr) + 1) >= hp;
    if (kind == KIND_LOAD) begin
      load_count++;
      tbl_exec[idx]   = exec_t;
      tbl_period[idx] = (per == 0) ? FIELD_W'(1) : per;
      tbl_left[idx]   = exec_t;
      tbl_ttpe[idx]   = tbl_period[idx];
      return;
    end
    tick_count++;
    for (int i = 0; i < n; i++)
      if (tbl_left[i] > tbl_ttpe[i]) ovr_flag = 1'b1;
    r.slot = slot_ctr;
    r.frame_end = last;
    if (ovr_flag) begin
      r.id = '0;
      r.idle = 1'b1;
      r.overrun = 1'b1;
      overrun_count++;
    end else begin
      found = 1'b0;
      chosen = 0;
      best = '0;
      for (int i = 0; i < n; i++) begin
        if (tbl_left[i] != 0 && (!found || tbl_period[i] < best)) begin
          found = 1'b1;
          chosen = i;
          best = tbl_period[i];
        end
      end
      if (found) tbl_left[chosen] = tbl_left[chosen] - 1'b1;
      for (int i = 0; i < n; i++) begin
        tbl_ttpe[i] = tbl_ttpe[i] - 1'b1;
        if (tbl_ttpe[i] == 0) begin
          tbl_left[i] = tbl_exec[i];
          tbl_ttpe[i] = tbl_period[i];
        end
      end
      r.id = found ? chosen[ID_W-1:0] : '0;
      r.idle = !found;
      r.overrun = 1'b0;
      if (found) run_count++;
      else idle_count++;
      slot_ctr = last ? '0 : slot_ctr + 1'b1;
    end
    expected_slots.push_back(r);
  endtask

  task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] idx,
                               input logic [FIELD_W-1:0] exec_t,
                               input logic [FIELD_W-1:0] per);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.task_index <= idx;
    in_ch.exec_time  <= exec_t;
    in_ch.period     <= per;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_schedule(kind, idx, exec_t, per);
  endtask

  task automatic issue_tick();
    issue_request(KIND_TICK, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  // sender holds off until every slot result is back, then lets loads settle
  task automatic wait_slots_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_TASK_COUNT) cfg_tasks = data[TC_W-1:0];
    else if (idx == REG_HYPERPERIOD) cfg_hyper = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_idle();
    repeat (2) issue_tick();
  endtask

  task automatic test_zero_period();
    wait_slots_drained();
    write_reg(REG_TASK_COUNT, 1);
    write_reg(REG_HYPERPERIOD, 16'hFFFF);
    issue_request(KIND_LOAD, 0, 1, 0);
    repeat (3) issue_tick();
  endtask

  // equal periods go to the lower index; last slot of the pattern is idle
  task automatic test_priority_order();
    wait_slots_drained();
    write_reg(REG_TASK_COUNT, 3);
    write_reg(REG_HYPERPERIOD, 5);
    issue_request(KIND_LOAD, 0, 1, 8);
    issue_request(KIND_LOAD, 1, 2, 4);
    issue_request(KIND_LOAD, 2, 1, 4);
    repeat (8) issue_tick();
  endtask

  task automatic test_frame_wrap();
    wait_slots_drained();
    write_reg(REG_TASK_COUNT, 0);
    write_reg(REG_HYPERPERIOD, 16'hFFFF);
    repeat (4) issue_tick();
    wait_slots_drained();
    write_reg(REG_HYPERPERIOD, 3);
    repeat (2) issue_tick();
  endtask

  // task sets stay under the rate monotonic utilization bound
  task automatic test_random_task_sets();
    int issued;
    int phase;
    int n;
    int used;
    int avail;
    int max_e;
    int ticks;
    logic [FIELD_W-1:0] p;
    logic [FIELD_W-1:0] e;
    logic [FIELD_W-1:0] hp;
    issued = 0;
    phase = 0;
    while (issued < RANDOM_REQS) begin
      if (issued >= 2 * RANDOM_REQS / 3) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else if (issued >= RANDOM_REQS / 3) begin
        send_gap_pct = 49;
        recv_gap_pct = 27;
      end else begin
        send_gap_pct = 27;
        recv_gap_pct = 49;
      end
      if (phase == 0) n = NUM_TASKS;
      else if ($urandom_range(3) == 0) n = $urandom_range(5, NUM_TASKS);
      else n = $urandom_range(0, 4);
      if (phase == 1) hp = 16'hFFFF;
      else if (phase == 2) hp = 1;
      else if ($urandom_range(3) == 0) hp = FIELD_W'($urandom_range(1, 65535));
      else hp = FIELD_W'($urandom_range(1, 24));
      wait_slots_drained();
      write_reg(REG_TASK_COUNT, CFG_DATA_W'(n));
      write_reg(REG_HYPERPERIOD, hp);
      used = 0;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) p = FIELD_W'($urandom_range(1000, 65535));
        else p = FIELD_W'($urandom_range(1, 48));
        avail = 690 - used;
        max_e = (avail * int'(p)) / 1000;
        e = FIELD_W'($urandom_range(0, max_e));
        used += (int'(e) * 1000 + int'(p) - 1) / int'(p);
        issue_request(KIND_LOAD, ID_W'(i), e, p);
        issued++;
      end
      ticks = $urandom_range(8, 30);
      for (int t = 0; t < ticks; t++) begin
        if (n < NUM_TASKS && $urandom_range(99) < 15) begin
          issue_request(KIND_LOAD, ID_W'($urandom_range(n, NUM_TASKS - 1)),
                        FIELD_W'($urandom), FIELD_W'($urandom));
          issued++;
        end
        issue_tick();
        issued++;
      end
      phase++;
    end
  endtask

  task automatic test_overrun_sticky();
    wait_slots_drained();
    write_reg(REG_TASK_COUNT, 2);
    write_reg(REG_HYPERPERIOD, 4);
    issue_request(KIND_LOAD, 0, 2, 8);
    issue_request(KIND_LOAD, 1, 16'hFFFF, 16'hFFFF);
    repeat (2) issue_tick();
    issue_request(KIND_LOAD, 0, 0, 1);
    issue_tick();
    wait_slots_drained();
    write_reg(REG_HYPERPERIOD, 1);
    issue_tick();
    for (int k = 0; k < 30; k++) begin
      if ($urandom_range(3) == 0)
        issue_request(KIND_LOAD, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      else
        issue_tick();
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  function automatic void report_field(string name, int unsigned exp_v, int unsigned got_v);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    slot_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_slots.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got slot %0d task %0d", $time,
                 out_ch.slot_number, out_ch.task_id);
      end else begin
        exp_r = expected_slots.pop_front();
        results_checked++;
        if (out_ch.slot_number !== exp_r.slot)
          report_field("slot_number", exp_r.slot, out_ch.slot_number);
        if (out_ch.task_id !== exp_r.id) report_field("task_id", exp_r.id, out_ch.task_id);
        if (out_ch.idle !== exp_r.idle) report_field("idle", exp_r.idle, out_ch.idle);
        if (out_ch.overrun !== exp_r.overrun)
          report_field("overrun", exp_r.overrun, out_ch.overrun);
        if (out_ch.frame_end !== exp_r.frame_end)
          report_field("frame_end", exp_r.frame_end, out_ch.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_rate_monotonic_tick_scheduler: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.task_index = '0;
    in_ch.exec_time = '0;
    in_ch.period = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TASK_COUNT;
    cfg_ch.data = '0;
    slot_ctr = '0;
    ovr_flag = 1'b0;
    cfg_tasks = '0;
    cfg_hyper = 1;
    mismatch_count = 0;
    results_checked = 0;
    load_count = 0;
    tick_count = 0;
    run_count = 0;
    idle_count = 0;
    overrun_count = 0;
    quiet_cycles = 0;
    send_gap_pct = 27;
    recv_gap_pct = 49;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_idle();
    test_zero_period();
    test_priority_order();
    test_frame_wrap();
    test_random_task_sets();
    test_overrun_sticky();
    wait_slots_drained();

    $display("requests: %0d loads, %0d ticks; %0d results checked", load_count, tick_count,
             results_checked);
    $display("slots: %0d task runs, %0d idle, %0d overrun", run_count, idle_count,
             overrun_count);
    if (mismatch_count == 0 && expected_slots.size() == 0) begin
      $display("tb_rate_monotonic_tick_scheduler: clean");
    end else begin
      $display("tb_rate_monotonic_tick_scheduler: errors");
    end
    $finish;
  end

endmodule
